// ===== src/two_pole_two_zero_filter_top_defines.svh =====
// assertion macros for the two-pole two-zero filter
`ifndef TWO_POLE_TWO_ZERO_FILTER_TOP_DEFINES_SVH
`define TWO_POLE_TWO_ZERO_FILTER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TPTZ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tptz assertion failed");

// next-cycle implication, checked out of reset
`define TPTZ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tptz assertion failed");

`endif

// ===== src/tptz_pkg.sv =====
// types, constants and microcode table of the two-pole two-zero filter
package tptz_pkg;

  localparam int SampleBits   = 24;
  localparam int CoefBits     = 24;
  localparam int CoefFracBits = 20;
  localparam int StateBits    = 32;
  localparam int ProdBits     = CoefBits + StateBits;
  localparam int AccBits      = ProdBits + 2;
  localparam int RndBits      = AccBits - CoefFracBits;
  localparam int NumRegs      = 6;
  localparam int RegIdxBits   = 3;
  localparam int StepBits     = 4;

  typedef logic [RegIdxBits-1:0] reg_idx_t;
  typedef logic [StepBits-1:0]   step_t;

  localparam reg_idx_t REG_INPUT_GAIN   = 3'd0;
  localparam reg_idx_t REG_FEEDBACK_ONE = 3'd1;
  localparam reg_idx_t REG_FEEDBACK_TWO = 3'd2;
  localparam reg_idx_t REG_FORWARD_ZERO = 3'd3;
  localparam reg_idx_t REG_FORWARD_ONE  = 3'd4;
  localparam reg_idx_t REG_FORWARD_TWO  = 3'd5;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam step_t STEP_FETCH  = 4'd0;
  localparam step_t STEP_MUL_X  = 4'd1;
  localparam step_t STEP_OUTPUT = 4'd10;
  localparam step_t STEP_CLEAR  = 4'd11;

  typedef enum logic [1:0] {
    OPND_X,
    OPND_D1,
    OPND_D2,
    OPND_W
  } opnd_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_e;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_FETCH,
    BR_DONE,
    BR_RESTART
  } br_e;

  typedef struct packed {
    reg_idx_t coef_sel;
    opnd_e    opnd;
    logic     mul_en;
    acc_e     acc_op;
    logic     w_load;
    logic     y_load;
    logic     clr_state;
    br_e      br;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t c;
    c = '{coef_sel: REG_INPUT_GAIN, opnd: OPND_X, mul_en: 1'b0, acc_op: ACC_HOLD,
          w_load: 1'b0, y_load: 1'b0, clr_state: 1'b0, br: BR_NEXT};
    unique case (step)
      4'd0:  c.br = BR_FETCH;
      4'd1:  begin c.coef_sel = REG_INPUT_GAIN;   c.opnd = OPND_X;  c.mul_en = 1'b1; end
      4'd2:  begin
        c.coef_sel = REG_FEEDBACK_ONE; c.opnd = OPND_D1; c.mul_en = 1'b1; c.acc_op = ACC_LOAD;
      end
      4'd3:  begin
        c.coef_sel = REG_FEEDBACK_TWO; c.opnd = OPND_D2; c.mul_en = 1'b1; c.acc_op = ACC_ADD;
      end
      4'd4:  c.acc_op = ACC_ADD;
      4'd5:  c.w_load = 1'b1;
      4'd6:  begin c.coef_sel = REG_FORWARD_ZERO; c.opnd = OPND_W;  c.mul_en = 1'b1; end
      4'd7:  begin
        c.coef_sel = REG_FORWARD_ONE; c.opnd = OPND_D1; c.mul_en = 1'b1; c.acc_op = ACC_LOAD;
      end
      4'd8:  begin
        c.coef_sel = REG_FORWARD_TWO; c.opnd = OPND_D2; c.mul_en = 1'b1; c.acc_op = ACC_ADD;
      end
      4'd9:  c.acc_op = ACC_ADD;
      4'd10: begin c.y_load = 1'b1; c.br = BR_DONE; end
      4'd11: begin c.clr_state = 1'b1; c.br = BR_RESTART; end
      default: c.br = BR_RESTART;
    endcase
    return c;
  endfunction

  // round half up, then floor shift by the coefficient fraction bits
  function automatic logic signed [RndBits-1:0] round_scale(input logic signed [AccBits-1:0] a);
    logic signed [AccBits-1:0] s;
    s = a + (AccBits'(1) <<< (CoefFracBits - 1));
    return RndBits'(s >>> CoefFracBits);
  endfunction

endpackage

// ===== src/two_pole_two_zero_filter_top.sv =====
// two-pole two-zero filter: microcoded sequencer over one shared multiplier
//
// input channel: in_valid_i, command_i, sample_in_i; in_stall_o is low only
// while the sequencer sits at its fetch step, and a transfer happens when
// in_valid_i is high and in_stall_o is low.
// output channel: out_valid_o, sample_out_o; the receiver holds out_stall_i
// high to stall, and the result holds until a transfer takes it.
// config channel: cfg_valid_i, cfg_index_i, cfg_data_i, cfg_ready_o (always
// high); indexes beyond the coefficient list are ignored.
// a filter command runs the microcode steps from its input transfer to
// out_valid_o, and the next input is taken once the sequencer is back at
// its fetch step. six products go one per step through the single 24x32
// multiplier, plus accumulate, round and fetch steps.
// a clear command moves to the clear step, which zeroes the state; it
// produces no output and then returns to the fetch step.
// a new input is taken while a result still waits; if the old result is
// still stalled when the next one is ready, the sequencer waits at its last
// step. reset clears coefficients, state, the step counter and out_valid_o.
`include "two_pole_two_zero_filter_top_defines.svh"

module two_pole_two_zero_filter_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   command_i,
  input  logic signed [tptz_pkg::SampleBits-1:0] sample_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [tptz_pkg::SampleBits-1:0] sample_out_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  tptz_pkg::reg_idx_t                     cfg_index_i,
  input  logic signed [tptz_pkg::CoefBits-1:0]   cfg_data_i
);

  localparam int SB = tptz_pkg::SampleBits;
  localparam int CB = tptz_pkg::CoefBits;
  localparam int WB = tptz_pkg::StateBits;
  localparam int PB = tptz_pkg::ProdBits;
  localparam int AB = tptz_pkg::AccBits;
  localparam int RB = tptz_pkg::RndBits;

  logic signed [CB-1:0] coef_q [tptz_pkg::NumRegs];
  tptz_pkg::step_t      step_q, step_d;
  logic signed [SB-1:0] x_q;
  logic signed [WB-1:0] d1_q, d2_q, w_q;
  logic signed [PB-1:0] prod_q;
  logic signed [AB-1:0] acc_q;
  logic signed [SB-1:0] y_q;
  logic                 out_valid_q, out_valid_d;

  tptz_pkg::ctrl_t      ctrl;
  logic                 in_xfer, out_xfer, slot_free, y_fire;
  logic signed [CB-1:0] coef_sel;
  logic signed [WB-1:0] opnd_sel;
  logic signed [RB-1:0] rnd;
  logic signed [WB-1:0] w_sat;
  logic signed [SB-1:0] y_sat;

  assign ctrl        = tptz_pkg::ucode(step_q);
  assign in_stall_o  = (step_q != tptz_pkg::STEP_FETCH);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign y_fire      = ctrl.y_load && slot_free;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign sample_out_o = y_q;

  assign coef_sel = (ctrl.coef_sel < tptz_pkg::reg_idx_t'(tptz_pkg::NumRegs)) ?
                    coef_q[ctrl.coef_sel[tptz_pkg::RegIdxBits-1:0]] : '0;

  always_comb begin
    unique case (ctrl.opnd)
      tptz_pkg::OPND_X:  opnd_sel = WB'(x_q);
      tptz_pkg::OPND_D1: opnd_sel = d1_q;
      tptz_pkg::OPND_D2: opnd_sel = d2_q;
      tptz_pkg::OPND_W:  opnd_sel = w_q;
      default:           opnd_sel = '0;
    endcase
  end

  assign rnd = tptz_pkg::round_scale(acc_q);

  always_comb begin
    if (rnd[RB-1:WB-1] == {(RB-WB+1){rnd[RB-1]}}) begin
      w_sat = rnd[WB-1:0];
    end else begin
      w_sat = rnd[RB-1] ? {1'b1, {(WB-1){1'b0}}} : {1'b0, {(WB-1){1'b1}}};
    end
    if (rnd[RB-1:SB-1] == {(RB-SB+1){rnd[RB-1]}}) begin
      y_sat = rnd[SB-1:0];
    end else begin
      y_sat = rnd[RB-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end
  end

  always_comb begin
    step_d = step_q;
    unique case (ctrl.br)
      tptz_pkg::BR_NEXT:    step_d = step_q + 1'b1;
      tptz_pkg::BR_FETCH: begin
        if (in_xfer) begin
          step_d = (command_i == tptz_pkg::CMD_CLEAR) ? tptz_pkg::STEP_CLEAR
                                                      : tptz_pkg::STEP_MUL_X;
        end
      end
      tptz_pkg::BR_DONE:    if (slot_free) step_d = tptz_pkg::STEP_FETCH;
      tptz_pkg::BR_RESTART: step_d = tptz_pkg::STEP_FETCH;
      default:              step_d = tptz_pkg::STEP_FETCH;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_xfer) out_valid_d = 1'b0;
    if (y_fire)   out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= tptz_pkg::STEP_FETCH;
      out_valid_q <= 1'b0;
      d1_q        <= '0;
      d2_q        <= '0;
      for (int i = 0; i < tptz_pkg::NumRegs; i++) coef_q[i] <= '0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o &&
          cfg_index_i < tptz_pkg::reg_idx_t'(tptz_pkg::NumRegs)) begin
        coef_q[cfg_index_i] <= cfg_data_i;
      end
      if (ctrl.clr_state) begin
        d1_q <= '0;
        d2_q <= '0;
      end else if (y_fire) begin
        d1_q <= w_q;
        d2_q <= d1_q;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) x_q <= sample_in_i;
    if (ctrl.mul_en) prod_q <= PB'(coef_sel * opnd_sel);
    unique case (ctrl.acc_op)
      tptz_pkg::ACC_LOAD: acc_q <= AB'(prod_q);
      tptz_pkg::ACC_ADD:  acc_q <= acc_q + AB'(prod_q);
      default:            acc_q <= acc_q;
    endcase
    if (ctrl.w_load) w_q <= w_sat;
    if (y_fire) y_q <= y_sat;
  end

  `TPTZ_ASSERT_NEXT(a_filter_start, in_xfer && command_i == tptz_pkg::CMD_FILTER,
                    step_q == tptz_pkg::STEP_MUL_X)
  `TPTZ_ASSERT_NEXT(a_clear_start, in_xfer && command_i == tptz_pkg::CMD_CLEAR,
                    step_q == tptz_pkg::STEP_CLEAR)
  `TPTZ_ASSERT_NEXT(a_clear_zeroes, step_q == tptz_pkg::STEP_CLEAR,
                    d1_q == '0 && d2_q == '0 && step_q == tptz_pkg::STEP_FETCH)
  `TPTZ_ASSERT_NOW(a_result_source, $rose(out_valid_q), $past(step_q) == tptz_pkg::STEP_OUTPUT)

endmodule
